@@ rtl/core/psp_pkg.sv @@
// Package for the packet slot pool manager: transfer item types, opcode and
// sequencer state enums, and default sizing constants.
// No dependencies.
package psp_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int OPCODE_W       = 2;
    localparam int SLOT_W         = 6;
    localparam int ACTIVE_W       = 7;
    localparam int ACTIVE_RESET   = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_SCAN  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UNLINK,
        ST_LINK,
        ST_TERM,
        ST_EMIT,
        ST_SCAN_READ,
        ST_SCAN_OUT
    } state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SLOT_W-1:0]   slot_index;
    } cmd_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              slot_valid;
        logic              reclaimed;
        logic              last_of_run;
    } rsp_item_t;

endpackage

@@ rtl/core/psp_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/packet_slot_pool_manager_unit.sv @@
// Top level of the packet slot pool manager: free and busy slot lists kept as
// doubly linked lists in RAM, driven by a small sequencer.
// Depends on psp_pkg and psp_ram.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+---------------------------
//  cmd     | in        | cmd_valid/stall  | psp_pkg::cmd_item_t
//  rsp     | out       | rsp_valid/stall  | psp_pkg::rsp_item_t
//  cfg     | in        | cfg_valid/ready  | cfg_data (active slot count)
//
// A get, or a put of a slot in the pool, runs read, unlink, link and term, then
// emit loads the result register; a put outside the pool goes straight to emit.
// A flush runs read, unlink, link and term per busy slot, a scan runs scan read
// and scan out. A stalled result waits in the output register while the next
// command is taken; a result behind it holds the sequencer and stalls commands.
// Reset, and any write of the active slot count, put the active slots on the
// free list in index order at once: per-entry valid bits make an unwritten
// link entry read as its initial value, so no clearing pass is needed.
module packet_slot_pool_manager_unit #(
    parameter int NUM_SLOTS = psp_pkg::DEF_NUM_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  psp_pkg::cmd_item_t                cmd,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output psp_pkg::rsp_item_t                rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psp_pkg::ACTIVE_W-1:0]      cfg_data
);

    // Link width holds every slot number plus the end marker, which is
    // NUM_SLOTS itself. RAM addresses only cover real slots.
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [LW-1:0] END_MARK = LW'(NUM_SLOTS);

    psp_pkg::state_t state_reg, state_next;

    logic [LW-1:0] pool_reg, pool_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] free_tail_reg, free_tail_next;
    logic [LW-1:0] busy_head_reg, busy_head_next;
    logic [LW-1:0] busy_tail_reg, busy_tail_next;
    logic [LW-1:0] slot_reg, slot_next;
    logic [LW-1:0] succ_reg, succ_next;
    psp_pkg::op_t  op_reg, op_next;
    logic          list_reg, list_next;
    logic          recl_reg, recl_next;

    // Valid bits: an entry whose bit is clear still holds its initial value.
    logic [NUM_SLOTS-1:0] next_vld_reg, next_vld_next;
    logic [NUM_SLOTS-1:0] prev_vld_reg, prev_vld_next;
    logic [NUM_SLOTS-1:0] busy_vld_reg, busy_vld_next;

    logic                rsp_valid_reg, rsp_valid_next;
    psp_pkg::rsp_item_t  rsp_reg, rsp_next;

    // RAM ports.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          next_we, prev_we, busy_we;
    logic [AW-1:0] next_waddr, prev_waddr, busy_waddr;
    logic [LW-1:0] next_wdata, prev_wdata;
    logic          busy_wdata;
    logic [LW-1:0] next_rdata, prev_rdata;
    logic          busy_rdata;

    // Effective entry of the slot being read.
    logic [AW-1:0] slot_addr;
    logic [LW-1:0] init_next, init_prev;
    logic [LW-1:0] ent_next, ent_prev;
    logic          ent_busy;
    logic [LW-1:0] tail_sel;
    logic          out_free;
    logic          cfg_write;
    logic [LW-1:0] cfg_pool;
    logic          idx_in_range;
    psp_pkg::op_t  cmd_op;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_op    = psp_pkg::op_t'(cmd.opcode);

    // Active count is clamped into 1 .. NUM_SLOTS.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_pool = LW'(1);
        end
        else if (cfg_data > psp_pkg::ACTIVE_W'(NUM_SLOTS))
        begin
            cfg_pool = END_MARK;
        end
        else
        begin
            cfg_pool = LW'(cfg_data);
        end
    end

    assign idx_in_range = {1'b0, cmd.slot_index} < psp_pkg::ACTIVE_W'(pool_reg);

    // Initial links: active slots chained in index order, both ends open.
    assign slot_addr = slot_reg[AW-1:0];
    assign init_next = ((slot_reg + LW'(1)) < pool_reg) ? (slot_reg + LW'(1)) : END_MARK;
    assign init_prev = ((slot_reg == '0) || (slot_reg >= pool_reg)) ? END_MARK
                                                                    : (slot_reg - LW'(1));
    assign ent_next  = next_vld_reg[slot_addr] ? next_rdata : init_next;
    assign ent_prev  = prev_vld_reg[slot_addr] ? prev_rdata : init_prev;
    assign ent_busy  = busy_vld_reg[slot_addr] ? busy_rdata : 1'b0;
    assign tail_sel  = list_reg ? busy_tail_reg : free_tail_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_op)
                        psp_pkg::OP_GET:
                        begin
                            state_next = psp_pkg::ST_READ;
                        end
                        psp_pkg::OP_PUT:
                        begin
                            state_next = idx_in_range ? psp_pkg::ST_READ : psp_pkg::ST_EMIT;
                        end
                        psp_pkg::OP_FLUSH:
                        begin
                            state_next = (busy_head_reg != END_MARK) ? psp_pkg::ST_READ
                                                                     : psp_pkg::ST_IDLE;
                        end
                        psp_pkg::OP_SCAN:
                        begin
                            state_next = (busy_head_reg != END_MARK) ? psp_pkg::ST_SCAN_READ
                                                                     : psp_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            state_next = psp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            psp_pkg::ST_READ:
            begin
                state_next = psp_pkg::ST_UNLINK;
            end
            psp_pkg::ST_UNLINK:
            begin
                state_next = psp_pkg::ST_LINK;
            end
            psp_pkg::ST_LINK:
            begin
                state_next = psp_pkg::ST_TERM;
            end
            psp_pkg::ST_TERM:
            begin
                if (op_reg == psp_pkg::OP_FLUSH)
                begin
                    state_next = (busy_head_reg != END_MARK) ? psp_pkg::ST_READ
                                                             : psp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = psp_pkg::ST_EMIT;
                end
            end
            psp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = psp_pkg::ST_IDLE;
                end
            end
            psp_pkg::ST_SCAN_READ:
            begin
                state_next = psp_pkg::ST_SCAN_OUT;
            end
            psp_pkg::ST_SCAN_OUT:
            begin
                if (out_free)
                begin
                    state_next = (ent_next == END_MARK) ? psp_pkg::ST_IDLE
                                                        : psp_pkg::ST_SCAN_READ;
                end
            end
            default:
            begin
                state_next = psp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and RAM port controls.
    always_comb
    begin
        cmd_stall  = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = slot_addr;
        next_we    = 1'b0;
        next_waddr = slot_addr;
        next_wdata = END_MARK;
        prev_we    = 1'b0;
        prev_waddr = slot_addr;
        prev_wdata = tail_sel;
        busy_we    = 1'b0;
        busy_waddr = slot_addr;
        busy_wdata = list_reg;
        unique case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            psp_pkg::ST_READ, psp_pkg::ST_SCAN_READ:
            begin
                rd_en = 1'b1;
            end
            psp_pkg::ST_UNLINK:
            begin
                // Bridge the neighbors of the slot over it.
                next_we    = (ent_prev != END_MARK);
                next_waddr = ent_prev[AW-1:0];
                next_wdata = ent_next;
                prev_we    = (ent_next != END_MARK);
                prev_waddr = ent_next[AW-1:0];
                prev_wdata = ent_prev;
            end
            psp_pkg::ST_LINK:
            begin
                // Hang the slot behind the tail of the target list.
                prev_we    = 1'b1;
                busy_we    = 1'b1;
                next_we    = (tail_sel != END_MARK);
                next_waddr = tail_sel[AW-1:0];
                next_wdata = slot_reg;
            end
            psp_pkg::ST_TERM:
            begin
                next_we = 1'b1;
            end
            psp_pkg::ST_EMIT, psp_pkg::ST_SCAN_OUT:
            begin
                cmd_stall = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Datapath and list registers.
    always_comb
    begin
        pool_next      = pool_reg;
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        busy_head_next = busy_head_reg;
        busy_tail_next = busy_tail_reg;
        slot_next      = slot_reg;
        succ_next      = succ_reg;
        op_next        = op_reg;
        list_next      = list_reg;
        recl_next      = recl_reg;
        next_vld_next  = next_vld_reg;
        prev_vld_next  = prev_vld_reg;
        busy_vld_next  = busy_vld_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (next_we)
        begin
            next_vld_next[next_waddr] = 1'b1;
        end
        if (prev_we)
        begin
            prev_vld_next[prev_waddr] = 1'b1;
        end
        if (busy_we)
        begin
            busy_vld_next[busy_waddr] = 1'b1;
        end

        case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next   = cmd_op;
                    recl_next = 1'b0;
                    case (cmd_op)
                        psp_pkg::OP_GET:
                        begin
                            list_next = 1'b1;
                            if (free_head_reg != END_MARK)
                            begin
                                slot_next = free_head_reg;
                            end
                            else
                            begin
                                slot_next = busy_head_reg;
                                recl_next = 1'b1;
                            end
                        end
                        psp_pkg::OP_PUT:
                        begin
                            list_next = 1'b0;
                            slot_next = LW'(cmd.slot_index);
                            succ_next = END_MARK;
                        end
                        default:
                        begin
                            list_next = 1'b0;
                            slot_next = busy_head_reg;
                        end
                    endcase
                end
            end
            psp_pkg::ST_UNLINK:
            begin
                succ_next = ent_next;
                if (ent_prev == END_MARK)
                begin
                    if (ent_busy)
                    begin
                        busy_head_next = ent_next;
                    end
                    else
                    begin
                        free_head_next = ent_next;
                    end
                end
                if (ent_next == END_MARK)
                begin
                    if (ent_busy)
                    begin
                        busy_tail_next = ent_prev;
                    end
                    else
                    begin
                        free_tail_next = ent_prev;
                    end
                end
            end
            psp_pkg::ST_LINK:
            begin
                if (list_reg)
                begin
                    busy_tail_next = slot_reg;
                    if (busy_tail_reg == END_MARK)
                    begin
                        busy_head_next = slot_reg;
                    end
                end
                else
                begin
                    free_tail_next = slot_reg;
                    if (free_tail_reg == END_MARK)
                    begin
                        free_head_next = slot_reg;
                    end
                end
            end
            psp_pkg::ST_TERM:
            begin
                // A flush keeps pulling the oldest busy slot; a get keeps its
                // slot and a put its successor for the result.
                if (op_reg == psp_pkg::OP_FLUSH)
                begin
                    slot_next = busy_head_reg;
                end
            end
            psp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.last_of_run = 1'b1;
                    if (op_reg == psp_pkg::OP_GET)
                    begin
                        rsp_next.slot_out   = psp_pkg::SLOT_W'(slot_reg);
                        rsp_next.slot_valid = 1'b1;
                        rsp_next.reclaimed  = recl_reg;
                    end
                    else
                    begin
                        rsp_next.reclaimed = 1'b0;
                        if (succ_reg == END_MARK)
                        begin
                            rsp_next.slot_out   = '0;
                            rsp_next.slot_valid = 1'b0;
                        end
                        else
                        begin
                            rsp_next.slot_out   = psp_pkg::SLOT_W'(succ_reg);
                            rsp_next.slot_valid = 1'b1;
                        end
                    end
                end
            end
            psp_pkg::ST_SCAN_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.slot_out    = psp_pkg::SLOT_W'(slot_reg);
                    rsp_next.slot_valid  = 1'b1;
                    rsp_next.reclaimed   = 1'b0;
                    rsp_next.last_of_run = (ent_next == END_MARK);
                    slot_next            = ent_next;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase

        // A count write rebuilds the pool; user must keep it to idle, unchecked.
        if (cfg_write)
        begin
            pool_next      = cfg_pool;
            free_head_next = '0;
            free_tail_next = cfg_pool - LW'(1);
            busy_head_next = END_MARK;
            busy_tail_next = END_MARK;
            next_vld_next  = '0;
            prev_vld_next  = '0;
            busy_vld_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psp_pkg::ST_IDLE;
            pool_reg      <= LW'(psp_pkg::ACTIVE_RESET > NUM_SLOTS ? NUM_SLOTS
                                                               : psp_pkg::ACTIVE_RESET);
            free_head_reg <= '0;
            free_tail_reg <= LW'((psp_pkg::ACTIVE_RESET > NUM_SLOTS ? NUM_SLOTS
                                                                : psp_pkg::ACTIVE_RESET) - 1);
            busy_head_reg <= END_MARK;
            busy_tail_reg <= END_MARK;
            next_vld_reg  <= '0;
            prev_vld_reg  <= '0;
            busy_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            op_reg        <= psp_pkg::OP_GET;
            list_reg      <= 1'b0;
            recl_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            busy_head_reg <= busy_head_next;
            busy_tail_reg <= busy_tail_next;
            next_vld_reg  <= next_vld_next;
            prev_vld_reg  <= prev_vld_next;
            busy_vld_reg  <= busy_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            op_reg        <= op_next;
            list_reg      <= list_next;
            recl_reg      <= recl_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        succ_reg <= succ_next;
        rsp_reg  <= rsp_next;
    end

    psp_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    psp_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    psp_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (busy_rdata)
    );

endmodule
